FILE: rtl/sorted_key_table_top_macros.svh
// Assertion macros for the sorted key table.
// Included by the top level; depends on nothing else.
`ifndef SORTED_KEY_TABLE_TOP_MACROS_SVH
`define SORTED_KEY_TABLE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SKT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SKT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

FILE: rtl/skt_pkg.sv
// Shared types and constants for the sorted key table.
// Used by skt_cell and sorted_key_table_top; depends on nothing.
`timescale 1ns / 1ps

package skt_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 64;
	localparam int KEY_W = 32;
	localparam int HANDLE_W = 32;
	localparam int CMD_W = 2;
	localparam int STATUS_W = 3;
	localparam int ENTRY_COUNT_W = 7;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_SEARCH = 2'd1,
		CMD_DELETE = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL      = 3'd2,
		ST_FOUND     = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_DELETED   = 3'd5
	} status_t;

	// Shift operation broadcast to every cell of the chain.
	typedef enum logic [1:0] {
		OP_NONE   = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		FSM_IDLE  = 2'd0,
		FSM_CMP   = 2'd1,
		FSM_APPLY = 2'd2
	} state_t;

	// Contents of one cell, also what a cell hands to its neighbors.
	typedef struct packed {
		logic                valid;
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] handle;
	} cell_data_t;

	// Broadcast control from the sequencer to all cells.
	typedef struct packed {
		logic                cmp_en;
		op_t                 op;
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] handle;
	} cell_ctrl_t;

endpackage

FILE: rtl/sorted_key_table_top.sv
// Sorted key table: a chain of record cells with a small command sequencer.
// Depends on skt_pkg, skt_cell and sorted_key_table_top_macros.svh.
`timescale 1ns / 1ps
`include "sorted_key_table_top_macros.svh"

// A command is taken when start is high and busy is low. In the compare state
// every cell compares its key with the command key in parallel; in the apply
// state the chain shifts by one slot to open or close a gap if the command
// changes the table; then the result is shown on status, found_handle and
// entry_count with done high. done is a one-cycle strobe and the receiver cannot
// stall it; the result must be taken in that cycle. A new command may be started
// in the same cycle as done. The table is empty after reset and needs no clearing.
module sorted_key_table_top #(
	parameter int TABLE_DEPTH = skt_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [skt_pkg::CMD_W-1:0]             command,
	input  logic signed [skt_pkg::KEY_W-1:0]      key_value,
	input  logic [skt_pkg::HANDLE_W-1:0]          record_handle,
	output logic                                  done,
	output logic [skt_pkg::STATUS_W-1:0]          status,
	output logic [skt_pkg::HANDLE_W-1:0]          found_handle,
	output logic [skt_pkg::ENTRY_COUNT_W-1:0]     entry_count
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	skt_pkg::state_t     state_q;
	skt_pkg::state_t     state_nxt;
	skt_pkg::cmd_t       cmd_q;
	logic [skt_pkg::KEY_W-1:0]    key_q;
	logic [skt_pkg::HANDLE_W-1:0] handle_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_nxt;

	skt_pkg::cell_ctrl_t ctrl;
	skt_pkg::cell_data_t cell_data [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] lt_vec;
	logic [TABLE_DEPTH-1:0] eq_vec;
	logic [TABLE_DEPTH-1:0] valid_vec;
	logic [TABLE_DEPTH:0]   valid_plus;

	logic                          hit;
	logic                          full;
	logic [skt_pkg::HANDLE_W-1:0]  match_handle;
	skt_pkg::op_t                  op_c;
	skt_pkg::status_t              status_c;
	logic [skt_pkg::HANDLE_W-1:0]  found_c;

	logic                          done_q;
	skt_pkg::status_t              status_q;
	logic [skt_pkg::HANDLE_W-1:0]  found_q;
	logic [31:0]                   count_ext;

	// Command capture on a start transfer.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_q    <= skt_pkg::cmd_t'(command);
			key_q    <= key_value;
			handle_q <= record_handle;
		end
	end

	// Sequencer next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			skt_pkg::FSM_IDLE: begin
				if (start) begin
					state_nxt = skt_pkg::FSM_CMP;
				end
			end
			skt_pkg::FSM_CMP: begin
				state_nxt = skt_pkg::FSM_APPLY;
			end
			skt_pkg::FSM_APPLY: begin
				state_nxt = skt_pkg::FSM_IDLE;
			end
			default: begin
				state_nxt = skt_pkg::FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skt_pkg::FSM_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Match and fill summary from the registered cell flags.
	always_comb begin
		match_handle = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			valid_vec[i] = cell_data[i].valid;
			if (eq_vec[i]) begin
				match_handle = match_handle | cell_data[i].handle;
			end
		end
		hit  = |eq_vec;
		full = cell_data[TABLE_DEPTH-1].valid;
	end

	assign valid_plus = {1'b0, valid_vec} + {{TABLE_DEPTH{1'b0}}, 1'b1};

	// Sequencer outputs: command decode in the apply cycle.
	always_comb begin
		op_c      = skt_pkg::OP_NONE;
		status_c  = skt_pkg::ST_NOT_FOUND;
		found_c   = '0;
		count_nxt = count_q;
		if (state_q == skt_pkg::FSM_APPLY) begin
			case (cmd_q)
				skt_pkg::CMD_INSERT: begin
					if (hit) begin
						status_c = skt_pkg::ST_DUPLICATE;
					end else if (full) begin
						status_c = skt_pkg::ST_FULL;
					end else begin
						status_c  = skt_pkg::ST_INSERTED;
						op_c      = skt_pkg::OP_INSERT;
						count_nxt = count_q + CNT_W'(1);
					end
				end
				skt_pkg::CMD_SEARCH: begin
					if (hit) begin
						status_c = skt_pkg::ST_FOUND;
						found_c  = match_handle;
					end
				end
				skt_pkg::CMD_DELETE: begin
					if (hit) begin
						status_c  = skt_pkg::ST_DELETED;
						op_c      = skt_pkg::OP_DELETE;
						count_nxt = count_q - CNT_W'(1);
					end
				end
				default: begin
					status_c = skt_pkg::ST_NOT_FOUND;
				end
			endcase
		end
		ctrl.cmp_en = (state_q == skt_pkg::FSM_CMP);
		ctrl.op     = op_c;
		ctrl.key    = key_q;
		ctrl.handle = handle_q;
		busy        = (state_q != skt_pkg::FSM_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_nxt;
			done_q  <= (state_q == skt_pkg::FSM_APPLY);
		end
	end

	// Result register, loaded in the apply state; it holds until the next apply and is new while done is high.
	always_ff @(posedge clk) begin
		if (state_q == skt_pkg::FSM_APPLY) begin
			status_q <= status_c;
			found_q  <= found_c;
		end
	end

	// The cell chain; the ends see an empty neighbor.
	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		skt_pkg::cell_data_t left_d;
		skt_pkg::cell_data_t right_d;
		logic                left_lt_d;

		if (g == 0) begin : g_first
			assign left_d    = '0;
			assign left_lt_d = 1'b1;
		end else begin : g_inner_l
			assign left_d    = cell_data[g-1];
			assign left_lt_d = lt_vec[g-1];
		end

		if (g == TABLE_DEPTH - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_inner_r
			assign right_d = cell_data[g+1];
		end

		skt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.left    (left_d),
			.left_lt (left_lt_d),
			.right   (right_d),
			.data    (cell_data[g]),
			.lt      (lt_vec[g]),
			.eq      (eq_vec[g])
		);
	end

	assign count_ext    = 32'(count_q);
	assign done         = done_q;
	assign status       = status_q;
	assign found_handle = found_q;
	assign entry_count  = count_ext[skt_pkg::ENTRY_COUNT_W-1:0];

	// Valid records always fill a prefix of the chain.
	`SKT_ASSERT_IMPL(a_valid_prefix, clk, arst_n, 1'b1, $onehot(valid_plus), "valid cells not a prefix")
	// The record count follows the valid cells.
	`SKT_ASSERT_IMPL(a_count_match, clk, arst_n, 1'b1, $countones(valid_vec) == int'(count_q), "count mismatch")
	// Full is reported only when every slot is taken.
	`SKT_ASSERT_IMPL(a_full_count, clk, arst_n, done_q && (status_q == skt_pkg::ST_FULL), count_q == CNT_W'(TABLE_DEPTH), "full with free slot")
	// Every transfer in produces its result strobe after the compare and apply states.
	`SKT_ASSERT_IMPL(a_result_timing, clk, arst_n, start && !busy, ##3 done_q, "result strobe missing")
	// An insert shift always grows the record count by one.
	`SKT_ASSERT_NEXT(a_insert_grows, clk, arst_n, op_c == skt_pkg::OP_INSERT, count_q == $past(count_q) + CNT_W'(1), "insert did not grow count")

endmodule

FILE: rtl/skt_cell.sv
// One slot of the sorted key chain: holds a record, compares it to the
// broadcast key and shifts in from a neighbor. Depends on skt_pkg.
`timescale 1ns / 1ps

module skt_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  skt_pkg::cell_ctrl_t ctrl,
	input  skt_pkg::cell_data_t left,
	input  logic                left_lt,
	input  skt_pkg::cell_data_t right,
	output skt_pkg::cell_data_t data,
	output logic                lt,
	output logic                eq
);

	logic                         valid_q;
	logic [skt_pkg::KEY_W-1:0]    key_q;
	logic [skt_pkg::HANDLE_W-1:0] handle_q;
	skt_pkg::cell_data_t          cur;
	skt_pkg::cell_data_t          nxt;
	logic                         lt_c;
	logic                         eq_c;
	logic                         lt_q;
	logic                         eq_q;

	// Stored record as seen by the compare and shift logic.
	always_comb begin
		cur.valid  = valid_q;
		cur.key    = key_q;
		cur.handle = handle_q;
	end

	// Signed compare of the stored key against the broadcast key.
	always_comb begin
		lt_c = cur.valid && ($signed(cur.key) < $signed(ctrl.key));
		eq_c = cur.valid && (cur.key == ctrl.key);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (ctrl.cmp_en) begin
			lt_q <= lt_c;
			eq_q <= eq_c;
		end
	end

	// Cells at or past the target slot shift right on insert, left on delete.
	// The first cell not below the key takes the new record on insert.
	always_comb begin
		nxt = cur;
		case (ctrl.op)
			skt_pkg::OP_INSERT: begin
				if (!lt_q) begin
					if (left_lt) begin
						nxt.valid  = 1'b1;
						nxt.key    = ctrl.key;
						nxt.handle = ctrl.handle;
					end else begin
						nxt = left;
					end
				end
			end
			skt_pkg::OP_DELETE: begin
				if (!lt_q) begin
					nxt = right;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	// Record payload carries no reset; an invalid slot is never read.
	always_ff @(posedge clk) begin
		key_q    <= nxt.key;
		handle_q <= nxt.handle;
	end

	assign data = cur;
	assign lt   = lt_q;
	assign eq   = eq_q;

endmodule

FILE: tb/sorted_key_table_top_tb.sv
// Self-checking testbench for the sorted key table top level.
// Depends on skt_pkg and sorted_key_table_top from the RTL; needs nothing else.
`timescale 1ns / 1ps

module sorted_key_table_top_tb;
	import skt_pkg::*;

	localparam int TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int KEY_POOL_SIZE = 80;
	localparam int RANDOM_ITEMS = 1730;
	localparam int MAX_GAP = 14;
	localparam int REPORT_LIMIT = 10;

	typedef enum int {PH_GROW, PH_SHRINK, PH_MIX} phase_kind_t;

	// One expected reply of the block.
	typedef struct {
		status_t                    status;
		logic [HANDLE_W-1:0]        found_handle;
		logic [ENTRY_COUNT_W-1:0]   entry_count;
	} table_reply_t;

	// Tracks the table contents and checks every reply against the oldest
	// prediction still waiting.
	class reply_scoreboard;
		logic signed [KEY_W-1:0] row_keys[TABLE_DEPTH];
		logic [HANDLE_W-1:0]     row_handles[TABLE_DEPTH];
		int                      entries;
		table_reply_t            pending_replies[$];
		int                      mismatch_count;
		int                      reply_count;
		int                      status_seen[6];

		function new();
			entries = 0;
			mismatch_count = 0;
			reply_count = 0;
			foreach (status_seen[i])
				status_seen[i] = 0;
		endfunction

		// Apply one accepted command to the table copy and queue its reply.
		function void note_command(logic [CMD_W-1:0] cmd, logic signed [KEY_W-1:0] key,
				logic [HANDLE_W-1:0] hdl);
			int           slot;
			bit           hit;
			table_reply_t reply;
			slot = 0;
			while (slot < entries && row_keys[slot] < key)
				slot++;
			hit = (slot < entries) && (row_keys[slot] == key);
			reply.status = ST_NOT_FOUND;
			reply.found_handle = '0;
			case (cmd)
				CMD_INSERT: begin
					if (hit) begin
						reply.status = ST_DUPLICATE;
					end else if (entries >= TABLE_DEPTH) begin
						reply.status = ST_FULL;
					end else begin
						for (int i = entries; i > slot; i--) begin
							row_keys[i] = row_keys[i-1];
							row_handles[i] = row_handles[i-1];
						end
						row_keys[slot] = key;
						row_handles[slot] = hdl;
						entries++;
						reply.status = ST_INSERTED;
					end
				end
				CMD_SEARCH: begin
					if (hit) begin
						reply.status = ST_FOUND;
						reply.found_handle = row_handles[slot];
					end
				end
				CMD_DELETE: begin
					if (hit) begin
						for (int i = slot; i < entries - 1; i++) begin
							row_keys[i] = row_keys[i+1];
							row_handles[i] = row_handles[i+1];
						end
						entries--;
						reply.status = ST_DELETED;
					end
				end
				default: begin
					// The unused command leaves the table alone.
				end
			endcase
			reply.entry_count = entries[ENTRY_COUNT_W-1:0];
			pending_replies.push_back(reply);
		endfunction

		// Compare one reply from the block with the oldest prediction.
		function void check_reply(logic [STATUS_W-1:0] st, logic [HANDLE_W-1:0] hdl,
				logic [ENTRY_COUNT_W-1:0] cnt);
			table_reply_t want;
			if (pending_replies.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("%0t: reply with none expected: status %0d handle %h count %0d",
						$realtime, st, hdl, cnt);
				return;
			end
			want = pending_replies.pop_front();
			reply_count++;
			status_seen[int'(want.status)]++;
			if (st !== want.status || hdl !== want.found_handle || cnt !== want.entry_count)
				begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("%0t: reply mismatch: status %0d/%0d handle %h/%h count %0d/%0d",
						$realtime, want.status, st, want.found_handle, hdl,
						want.entry_count, cnt);
			end
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic [CMD_W-1:0]         command = CMD_SEARCH;
	logic signed [KEY_W-1:0]  key_value = '0;
	logic [HANDLE_W-1:0]      record_handle = '0;
	logic                     done;
	logic [STATUS_W-1:0]      status;
	logic [HANDLE_W-1:0]      found_handle;
	logic [ENTRY_COUNT_W-1:0] entry_count;

	reply_scoreboard          board = new();
	logic signed [KEY_W-1:0]  key_pool[KEY_POOL_SIZE];
	int                       commands_sent = 0;

	sorted_key_table_top #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.key_value(key_value),
		.record_handle(record_handle),
		.done(done),
		.status(status),
		.found_handle(found_handle),
		.entry_count(entry_count)
	);

	always #5 clk = ~clk;

	// Watch both sides at every edge: check replies, then note new transfers.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				board.check_reply(status, found_handle, entry_count);
			if (start && !busy)
				board.note_command(command, key_value, record_handle);
		end
	end

	// Present one command, hold it until the transfer, then, if a gap is asked for, drop start and idle for it.
	task automatic issue_command(input logic [CMD_W-1:0] cmd,
			input logic signed [KEY_W-1:0] key, input logic [HANDLE_W-1:0] hdl,
			input int gap);
		start <= 1'b1;
		command <= cmd;
		key_value <= key;
		record_handle <= hdl;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		commands_sent++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold off new commands until every predicted reply has come back.
	task automatic wait_for_replies();
		start <= 1'b0;
		@(posedge clk);
		while (board.pending_replies.size() != 0)
			@(posedge clk);
	endtask

	// Directed part: extremes of key and handle, every command, empty table,
	// duplicates, the unused command, and removal at head, middle and tail.
	task automatic run_directed();
		issue_command(CMD_SEARCH, 32'sd0, 32'h0, 0);
		issue_command(CMD_DELETE, 32'sd5, 32'h0, 1);
		issue_command(CMD_UNUSED, 32'sd0, 32'hFFFF_FFFF, 0);
		issue_command(CMD_INSERT, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 2);
		issue_command(CMD_INSERT, 32'sh8000_0000, 32'h0000_0000, 0);
		issue_command(CMD_INSERT, 32'sd0, 32'h1234_5678, 0);
		issue_command(CMD_INSERT, -32'sd1, 32'hA5A5_A5A5, 3);
		issue_command(CMD_INSERT, 32'sh7FFF_FFFF, 32'h0000_0001, 0);
		issue_command(CMD_SEARCH, 32'sh8000_0000, 32'h5A5A_5A5A, 0);
		issue_command(CMD_SEARCH, 32'sh7FFF_FFFF, 32'h0, 1);
		issue_command(CMD_SEARCH, -32'sd1, 32'h0, 0);
		issue_command(CMD_SEARCH, 32'sd1, 32'h0, 0);
		issue_command(CMD_UNUSED, -32'sd1, 32'hDEAD_BEEF, 0);
		issue_command(CMD_SEARCH, -32'sd1, 32'h0, 4);
		issue_command(CMD_DELETE, 32'sd0, 32'h0, 0);
		issue_command(CMD_DELETE, 32'sd0, 32'h0, 0);
		issue_command(CMD_DELETE, 32'sh8000_0000, 32'h0, 0);
		issue_command(CMD_DELETE, 32'sh7FFF_FFFF, 32'h0, 2);
		issue_command(CMD_SEARCH, 32'sd0, 32'h0, 0);
		issue_command(CMD_INSERT, 32'sh7FFF_FFFE, 32'h8000_0001, 0);
		issue_command(CMD_DELETE, -32'sd1, 32'h0, 0);
		issue_command(CMD_DELETE, 32'sh7FFF_FFFE, 32'h0, 0);
		wait_for_replies();
	endtask

	// Random part: phases that grow, shrink or churn the table, with keys
	// drawn mostly from a fixed pool so that hits and duplicates are common.
	task automatic run_random();
		int               random_sent;
		int               phase_len;
		int               pick;
		int               gap;
		bit               no_idle;
		bit               first_phase;
		phase_kind_t      phase;
		logic [CMD_W-1:0] cmd;
		logic signed [KEY_W-1:0] key;
		random_sent = 0;
		first_phase = 1'b1;
		while (random_sent < RANDOM_ITEMS) begin
			if (first_phase) begin
				phase = PH_GROW;
				phase_len = 220;
			end else begin
				phase = phase_kind_t'($urandom_range(0, 2));
				phase_len = $urandom_range(40, 150);
			end
			no_idle = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < phase_len && random_sent < RANDOM_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				case (phase)
					PH_GROW:   cmd = (pick < 85) ? CMD_INSERT : (pick < 92) ? CMD_SEARCH :
						(pick < 97) ? CMD_DELETE : CMD_UNUSED;
					PH_SHRINK: cmd = (pick < 15) ? CMD_INSERT : (pick < 35) ? CMD_SEARCH :
						(pick < 97) ? CMD_DELETE : CMD_UNUSED;
					default:   cmd = (pick < 35) ? CMD_INSERT : (pick < 65) ? CMD_SEARCH :
						(pick < 97) ? CMD_DELETE : CMD_UNUSED;
				endcase
				if ($urandom_range(0, 9) == 0)
					key = $urandom;
				else
					key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
				gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
				issue_command(cmd, key, $urandom, gap);
				if (cmd != CMD_UNUSED)
					random_sent++;
			end
			// The sender waits out every reply after the first phase and now
			// and then later on.
			if (first_phase || $urandom_range(0, 2) == 0)
				wait_for_replies();
			first_phase = 1'b0;
		end
		start <= 1'b0;
	endtask

	// Main sequence: reset, directed, random, drain and verdict.
	initial begin
		key_pool[0] = 32'sh8000_0000;
		key_pool[1] = 32'sh7FFF_FFFF;
		key_pool[2] = 32'sd0;
		key_pool[3] = -32'sd1;
		for (int i = 4; i < KEY_POOL_SIZE; i++)
			key_pool[i] = $urandom;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		@(posedge clk);
		while (board.pending_replies.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("Checked %0d replies to %0d commands: %0d inserted, %0d duplicate, %0d full,",
			board.reply_count, commands_sent, board.status_seen[ST_INSERTED],
			board.status_seen[ST_DUPLICATE], board.status_seen[ST_FULL]);
		$display("%0d found, %0d not found, %0d deleted; %0d mismatches.",
			board.status_seen[ST_FOUND], board.status_seen[ST_NOT_FOUND],
			board.status_seen[ST_DELETED], board.mismatch_count);
		if (board.mismatch_count == 0 && board.pending_replies.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Timeout far beyond the slowest correct run.
	initial begin
		#(2_000_000);
		$display("Timeout with %0d replies outstanding.", board.pending_replies.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/skt_pkg.sv
rtl/skt_cell.sv
rtl/sorted_key_table_top.sv
tb/sorted_key_table_top_tb.sv
